### src/ftbfd_pkg.sv
`timescale 1ns / 1ps

package ftbfd_pkg;

  // Channel count and field widths
  localparam int NCH        = 6;
  localparam int CH_W       = 24;
  localparam int OUT_W      = 25;
  localparam int SUM_W      = 31;
  localparam int DIFF_W     = 26;
  localparam int WGT_W      = 17;
  localparam int DB_W       = 23;
  localparam int PROD_W     = 44;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Unity weight in Q1.16
  localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

  // Register reset values
  localparam logic [WGT_W-1:0] NEW_WEIGHT_RST = 17'd62259;
  localparam logic [DB_W-1:0]  XY_DB_RST      = 23'd3277;
  localparam logic [DB_W-1:0]  Z_DB_RST       = 23'd410;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XY_DB      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_DB       = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_CAL      = 3'd0,
    ST_CAL_DONE = 3'd1,
    ST_CAL_FAIL = 3'd2,
    ST_ACCEPT   = 3'd3,
    ST_REJECT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_CAL,
    PH_DIV,
    PH_LOAD,
    PH_RUN
  } phase_t;

  // Control from the sequencer to every lane
  typedef struct packed {
    logic    s1_load;
    logic    s2_load;
    logic    s3_load;
    logic    out_load;
    status_t fin_st;
    logic    cal_add;
    logic    cal_clear;
    logic    div_load;
    logic    div_step;
    logic    bias_load;
    logic    run_load;
  } lane_ctl_t;

endpackage

### src/ftbfd_if.sv
`timescale 1ns / 1ps

interface ftbfd_in_if;
  import ftbfd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [CH_W-1:0] force_x;
  logic signed [CH_W-1:0] force_y;
  logic signed [CH_W-1:0] force_z;
  logic signed [CH_W-1:0] torque_x;
  logic signed [CH_W-1:0] torque_y;
  logic signed [CH_W-1:0] torque_z;

  modport source(output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                 input ready);
  modport sink(input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               output ready);
endinterface

interface ftbfd_out_if;
  import ftbfd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] out_force_x;
  logic signed [OUT_W-1:0] out_force_y;
  logic signed [OUT_W-1:0] out_force_z;
  logic signed [OUT_W-1:0] out_torque_x;
  logic signed [OUT_W-1:0] out_torque_y;
  logic signed [OUT_W-1:0] out_torque_z;
  logic [STAT_W-1:0]       status;

  modport source(output valid, out_force_x, out_force_y, out_force_z, out_torque_x,
                 out_torque_y, out_torque_z, status, input ready);
  modport sink(input valid, out_force_x, out_force_y, out_force_z, out_torque_x,
               out_torque_y, out_torque_z, status, output ready);
endinterface

### src/ftbfd_lane.sv
`timescale 1ns / 1ps

module ftbfd_lane #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [ftbfd_pkg::CH_W-1:0] x,
  input  ftbfd_pkg::lane_ctl_t             ctl,
  input  logic [ftbfd_pkg::WGT_W-1:0]      wgt,
  input  logic [ftbfd_pkg::DB_W-1:0]       db,
  output logic                             x_zero,
  output logic                             sum_zero,
  output logic signed [ftbfd_pkg::OUT_W-1:0] y
);
  import ftbfd_pkg::*;

  // |sum| stays below 2^30 for up to 127 samples of 24 bits
  localparam int MAG_W = SUM_W - 1;
  localparam int SHIFT = MAG_W + $clog2(CAL_SAMPLES);
  localparam logic [MAG_W:0] RECIP =
    (MAG_W + 1)'(((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  logic signed [SUM_W-1:0]  sum_r, sum_nxt, sum_add;
  logic                     neg_r, neg_nxt;
  logic [SUM_W-1:0]         quo_r, quo_nxt;
  logic [2*MAG_W:0]         quo_prod;
  logic signed [CH_W-1:0]   bias_r, bias_nxt;
  logic signed [OUT_W-1:0]  prev_r, prev_nxt;
  logic signed [OUT_W-1:0]  last_r, last_nxt;
  logic signed [OUT_W-1:0]  d_in;

  logic signed [OUT_W-1:0]  d1_r, p1_r;
  logic signed [DIFF_W-1:0] diff2_r;
  logic signed [OUT_W-1:0]  p2_r;
  logic signed [PROD_W-1:0] prod3_r;
  logic signed [OUT_W-1:0]  p3_r;
  logic signed [OUT_W-1:0]  y_r;

  logic signed [PROD_W-1:0] blend;
  logic signed [OUT_W-1:0]  filt, filt_db, fin;
  logic [OUT_W-1:0]         filt_mag;

  // Calibration sum
  assign sum_add  = sum_r + SUM_W'(x);
  assign sum_zero = (sum_add == '0);
  assign x_zero   = (x == '0);

  always_comb begin
    sum_nxt = sum_r;
    if (ctl.cal_clear) begin
      sum_nxt = '0;
    end else if (ctl.cal_add) begin
      sum_nxt = sum_add;
    end
  end

  // Divide |sum| by the sample count: one multiply by a rounded-up reciprocal,
  // exact for every magnitude below 2^30
  assign quo_prod = {{(MAG_W + 1){1'b0}}, quo_r[MAG_W-1:0]} * {{MAG_W{1'b0}}, RECIP};

  always_comb begin
    neg_nxt = neg_r;
    quo_nxt = quo_r;
    if (ctl.div_load) begin
      neg_nxt = sum_add[SUM_W-1];
      quo_nxt = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
    end else if (ctl.div_step) begin
      quo_nxt = SUM_W'(quo_prod >> SHIFT);
    end
  end

  // Apply sign to the quotient: truncation toward zero
  always_comb begin
    bias_nxt = bias_r;
    if (ctl.bias_load) begin
      bias_nxt = neg_r ? -quo_r[CH_W-1:0] : quo_r[CH_W-1:0];
    end
  end

  // Debias at the input and remember it for the next blend
  assign d_in = OUT_W'(x) - OUT_W'(bias_r);

  always_comb begin
    prev_nxt = prev_r;
    if (ctl.run_load) begin
      prev_nxt = d_in;
    end
  end

  // Blend: p*2^16 + w*(d - p), then floor by 2^16
  assign blend    = (PROD_W'(p3_r) <<< 16) + prod3_r;
  assign filt     = blend[OUT_W+15:16];
  assign filt_mag = filt[OUT_W-1] ? OUT_W'(-filt) : OUT_W'(filt);
  assign filt_db  = (filt_mag < OUT_W'(db)) ? '0 : filt;

  // Pick the result word by status
  always_comb begin
    case (ctl.fin_st)
      ST_ACCEPT: fin = filt_db;
      ST_REJECT: fin = last_r;
      default:   fin = '0;
    endcase
  end

  always_comb begin
    last_nxt = last_r;
    if (ctl.out_load && ctl.fin_st == ST_ACCEPT) begin
      last_nxt = filt_db;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      bias_r <= '0;
      prev_r <= '0;
      last_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      bias_r <= bias_nxt;
      prev_r <= prev_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  // Datapath stages: advance on their load strobes
  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      d1_r <= d_in;
      p1_r <= prev_r;
    end
    if (ctl.s2_load) begin
      diff2_r <= DIFF_W'(d1_r) - DIFF_W'(p1_r);
      p2_r    <= p1_r;
    end
    if (ctl.s3_load) begin
      prod3_r <= PROD_W'($signed({1'b0, wgt}) * diff2_r);
      p3_r    <= p2_r;
    end
    if (ctl.out_load) begin
      y_r <= fin;
    end
  end

  assign y = y_r;

endmodule

### src/ftbfd_ctrl.sv
`timescale 1ns / 1ps

module ftbfd_ctrl #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  out_ready,
  input  logic                  any_x_zero,
  input  logic                  all_sum_zero,
  output logic                  in_ready,
  output logic                  out_valid,
  output ftbfd_pkg::status_t    out_status,
  output ftbfd_pkg::lane_ctl_t  ctl
);
  import ftbfd_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(CAL_SAMPLES - 1);

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              v1_r, v2_r, v3_r, ov_r;
  status_t           st1_r, st2_r, st3_r, ost_r;
  status_t           st_in;
  logic              acc, open, last_cal;
  logic              div_step, bias_load;
  logic              s2_load, s3_load, out_load;

  // Collapsing pipeline: a stage moves when the next is empty or moving
  assign out_load = v3_r && (!ov_r || out_ready);
  assign s3_load  = v2_r && (!v3_r || out_load);
  assign s2_load  = v1_r && (!v2_r || s3_load);
  assign in_ready = open && (!v1_r || s2_load);
  assign acc      = in_valid && in_ready;
  assign last_cal = (cnt_r == CNT_LAST);

  // Status of the arriving word
  always_comb begin
    if (phase_r == PH_CAL) begin
      if (!last_cal) begin
        st_in = ST_CAL;
      end else if (all_sum_zero) begin
        st_in = ST_CAL_FAIL;
      end else begin
        st_in = ST_CAL_DONE;
      end
    end else begin
      st_in = any_x_zero ? ST_REJECT : ST_ACCEPT;
    end
  end

  // Phase next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_CAL:  if (acc && st_in == ST_CAL_DONE) phase_nxt = PH_DIV;
      PH_DIV:  phase_nxt = PH_LOAD;
      PH_LOAD: phase_nxt = PH_RUN;
      PH_RUN:  phase_nxt = PH_RUN;
      default: phase_nxt = PH_CAL;
    endcase
  end

  // Phase outputs
  always_comb begin
    open      = 1'b0;
    div_step  = 1'b0;
    bias_load = 1'b0;
    unique case (phase_r)
      PH_CAL:  open = 1'b1;
      PH_DIV:  div_step = 1'b1;
      PH_LOAD: bias_load = 1'b1;
      PH_RUN:  open = 1'b1;
      default: open = 1'b0;
    endcase
  end

  // Lane strobes
  always_comb begin
    ctl.s1_load   = acc;
    ctl.s2_load   = s2_load;
    ctl.s3_load   = s3_load;
    ctl.out_load  = out_load;
    ctl.fin_st    = st3_r;
    ctl.cal_add   = acc && (st_in == ST_CAL || st_in == ST_CAL_DONE);
    ctl.cal_clear = acc && (st_in == ST_CAL_FAIL);
    ctl.div_load  = acc && (st_in == ST_CAL_DONE);
    ctl.div_step  = div_step;
    ctl.bias_load = bias_load;
    ctl.run_load  = acc && (st_in == ST_ACCEPT);
  end

  // Sample counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.cal_clear) begin
      cnt_nxt = '0;
    end else if (acc && st_in == ST_CAL) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CAL;
      cnt_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      v1_r    <= acc || (v1_r && !s2_load);
      v2_r    <= s2_load || (v2_r && !s3_load);
      v3_r    <= s3_load || (v3_r && !out_load);
      ov_r    <= out_load || (ov_r && !out_ready);
    end
  end

  // Status travels with its word
  always_ff @(posedge clk) begin
    if (acc) st1_r <= st_in;
    if (s2_load) st2_r <= st1_r;
    if (s3_load) st3_r <= st2_r;
    if (out_load) ost_r <= st3_r;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;

`ifndef SYNTHESIS
  a_closed_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIV || phase_r == PH_LOAD) |-> !in_ready)
    else $error("input open during bias divide");

  a_done_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && st_in == ST_CAL_DONE) |=> (phase_r == PH_DIV))
    else $error("calibration done did not start the divide");

  a_run_status_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (st_in == ST_ACCEPT || st_in == ST_REJECT)) |-> phase_r == PH_RUN)
    else $error("run status outside run phase");

  a_out_load_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> ov_r)
    else $error("output register lost a word");
`endif

endmodule

### src/force_torque_bias_filter_deadband_core.sv
`timescale 1ns / 1ps
// An accepted input word moves through the input, difference, product and
// output registers. Throughput: one word per cycle unless output stalls; the
// six channels run in parallel lanes. After calibration, input stalls while
// lane sums are divided by CAL_SAMPLES by reciprocal multiply, then signed.
// Reset (synchronous, rst_n low): calibration restarts, sums, bias and
// filter history clear, registers return to their defaults.

module force_torque_bias_filter_deadband_core #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ftbfd_in_if.sink                             in_ch,
  ftbfd_out_if.source                          out_ch,
  input  logic                                 cfg_we,
  input  logic [ftbfd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ftbfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ftbfd_pkg::*;

  logic [WGT_W-1:0]        new_weight_r, new_weight_nxt;
  logic [DB_W-1:0]         xy_db_r, xy_db_nxt;
  logic [DB_W-1:0]         z_db_r, z_db_nxt;
  logic [WGT_W-1:0]        wgt;
  logic signed [CH_W-1:0]  x_in [NCH];
  logic signed [OUT_W-1:0] y_out [NCH];
  logic [DB_W-1:0]         db_lane [NCH];
  logic [NCH-1:0]          x_zero, sum_zero;
  lane_ctl_t               ctl;
  status_t                 out_status;

  // Configuration writes
  always_comb begin
    new_weight_nxt = new_weight_r;
    xy_db_nxt      = xy_db_r;
    z_db_nxt       = z_db_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NEW_WEIGHT: new_weight_nxt = cfg_data[WGT_W-1:0];
        CFG_XY_DB:      xy_db_nxt = cfg_data[DB_W-1:0];
        CFG_Z_DB:       z_db_nxt = cfg_data[DB_W-1:0];
        default:        new_weight_nxt = new_weight_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_weight_r <= NEW_WEIGHT_RST;
      xy_db_r      <= XY_DB_RST;
      z_db_r       <= Z_DB_RST;
    end else begin
      new_weight_r <= new_weight_nxt;
      xy_db_r      <= xy_db_nxt;
      z_db_r       <= z_db_nxt;
    end
  end

  // Clamp the weight to unity
  assign wgt = (new_weight_r > ONE_Q16) ? ONE_Q16 : new_weight_r;

  // Lane inputs; force lanes get no deadband
  assign x_in[0]    = in_ch.force_x;
  assign x_in[1]    = in_ch.force_y;
  assign x_in[2]    = in_ch.force_z;
  assign x_in[3]    = in_ch.torque_x;
  assign x_in[4]    = in_ch.torque_y;
  assign x_in[5]    = in_ch.torque_z;
  assign db_lane[0] = '0;
  assign db_lane[1] = '0;
  assign db_lane[2] = '0;
  assign db_lane[3] = xy_db_r;
  assign db_lane[4] = xy_db_r;
  assign db_lane[5] = z_db_r;

  for (genvar i = 0; i < NCH; i++) begin : g_lane
    ftbfd_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .x        (x_in[i]),
      .ctl      (ctl),
      .wgt      (wgt),
      .db       (db_lane[i]),
      .x_zero   (x_zero[i]),
      .sum_zero (sum_zero[i]),
      .y        (y_out[i])
    );
  end

  // Merge lane flags and sequence the pipeline
  ftbfd_ctrl #(.CAL_SAMPLES(CAL_SAMPLES)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .out_ready    (out_ch.ready),
    .any_x_zero   (|x_zero),
    .all_sum_zero (&sum_zero),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_status   (out_status),
    .ctl          (ctl)
  );

  assign out_ch.out_force_x  = y_out[0];
  assign out_ch.out_force_y  = y_out[1];
  assign out_ch.out_force_z  = y_out[2];
  assign out_ch.out_torque_x = y_out[3];
  assign out_ch.out_torque_y = y_out[4];
  assign out_ch.out_torque_z = y_out[5];
  assign out_ch.status       = out_status;

endmodule

### dv/force_torque_bias_filter_deadband_checker.sv
`timescale 1ns / 1ps

module force_torque_bias_filter_deadband_checker #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ftbfd_in_if                              in_mon,
  ftbfd_out_if                             out_mon,
  input  logic                             cfg_we,
  input  logic [ftbfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ftbfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               mismatches,
  output int                               words_pending
);
  import ftbfd_pkg::*;

  typedef logic [NCH-1:0][CH_W-1:0] ft_sample_t;

  typedef struct packed {
    logic [NCH-1:0][OUT_W-1:0] ch;
    status_t                   st;
  } ft_word_t;

  string ch_names [NCH] = '{"out_force_x", "out_force_y", "out_force_z",
                            "out_torque_x", "out_torque_y", "out_torque_z"};

  // Shadow copy of the registers
  logic [WGT_W-1:0] weight_reg;
  logic [DB_W-1:0]  xy_band;
  logic [DB_W-1:0]  z_band;

  // Shadow copy of the calibration and filter state
  logic                     cal_active;
  int                       cal_cnt;
  logic signed [SUM_W-1:0]  cal_sum   [NCH];
  logic signed [CH_W-1:0]   bias_v    [NCH];
  logic signed [OUT_W-1:0]  prev_deb  [NCH];
  logic signed [OUT_W-1:0]  last_filt [NCH];

  // Filtered words still owed by the block, oldest first
  ft_word_t filtered_q [$];

  // Advance the shadow state by one sample and return the word it yields
  function automatic ft_word_t predict_filtered(input ft_sample_t smp);
    ft_word_t res;
    longint   x [NCH];
    longint   w;
    longint   d;
    longint   f;
    longint   band;
    bit       any_zero;
    bit       sums_zero;
    res = '0;
    any_zero = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      x[i] = longint'($signed(smp[i]));
      if (x[i] == 0) any_zero = 1'b1;
    end
    if (cal_active) begin
      for (int i = 0; i < NCH; i++) cal_sum[i] = cal_sum[i] + $signed(smp[i]);
      cal_cnt++;
      if (cal_cnt < CAL_SAMPLES) begin
        res.st = ST_CAL;
      end else begin
        sums_zero = 1'b1;
        for (int i = 0; i < NCH; i++) if (cal_sum[i] != 0) sums_zero = 1'b0;
        if (sums_zero) begin
          // Restart the calibration from scratch
          for (int i = 0; i < NCH; i++) cal_sum[i] = '0;
          cal_cnt = 0;
          res.st = ST_CAL_FAIL;
        end else begin
          for (int i = 0; i < NCH; i++) bias_v[i] = CH_W'(longint'(cal_sum[i]) / CAL_SAMPLES);
          cal_active = 1'b0;
          res.st = ST_CAL_DONE;
        end
      end
      return res;
    end
    // Repeat the last filtered vector on a dropped sample
    if (!any_zero) begin
      w = (weight_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(weight_reg);
      for (int i = 0; i < NCH; i++) begin
        d = x[i] - longint'(bias_v[i]);
        f = (w * d + (longint'(ONE_Q16) - w) * longint'(prev_deb[i])) >>> 16;
        if (i >= 3) begin
          band = (i == 5) ? longint'(z_band) : longint'(xy_band);
          if ((f < 0 ? -f : f) < band) f = 0;
        end
        prev_deb[i]  = OUT_W'(d);
        last_filt[i] = OUT_W'(f);
      end
    end
    for (int i = 0; i < NCH; i++) res.ch[i] = last_filt[i];
    res.st = any_zero ? ST_REJECT : ST_ACCEPT;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    ft_word_t want;
    ft_word_t got;
    ft_word_t fresh;
    if (!rst_n) begin
      weight_reg = NEW_WEIGHT_RST;
      xy_band    = XY_DB_RST;
      z_band     = Z_DB_RST;
      cal_active = 1'b1;
      cal_cnt    = 0;
      for (int i = 0; i < NCH; i++) begin
        cal_sum[i]   = '0;
        bias_v[i]    = '0;
        prev_deb[i]  = '0;
        last_filt[i] = '0;
      end
      filtered_q.delete();
      mismatches = 0;
    end else begin
      // Compare an accepted result word with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got.ch = {out_mon.out_torque_z, out_mon.out_torque_y, out_mon.out_torque_x,
                  out_mon.out_force_z, out_mon.out_force_y, out_mon.out_force_x};
        got.st = status_t'(out_mon.status);
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual status %0d",
                   $time, out_mon.status);
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          for (int i = 0; i < NCH; i++) begin
            if (got.ch[i] !== want.ch[i]) begin
              $display("%0t: %s expected %0d actual %0d", $time, ch_names[i],
                       $signed(want.ch[i]), $signed(got.ch[i]));
              mismatches++;
            end
          end
          if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            mismatches++;
          end
        end
      end
      // Track register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_idx)
          CFG_NEW_WEIGHT: weight_reg = cfg_data[WGT_W-1:0];
          CFG_XY_DB:      xy_band    = cfg_data[DB_W-1:0];
          CFG_Z_DB:       z_band     = cfg_data[DB_W-1:0];
          default: ;
        endcase
      end
      // Predict the word for an accepted sample and queue it at the tail
      if (in_mon.valid && in_mon.ready) begin
        fresh = predict_filtered({in_mon.torque_z, in_mon.torque_y,
                                  in_mon.torque_x, in_mon.force_z,
                                  in_mon.force_y, in_mon.force_x});
        filtered_q = {filtered_q, fresh};
      end
    end
    words_pending = filtered_q.size();
  end

endmodule

### dv/force_torque_bias_filter_deadband_core_test.sv
`timescale 1ns / 1ps

module force_torque_bias_filter_deadband_core_test;
  import ftbfd_pkg::*;

  localparam int CAL_N          = 100;
  localparam int ITEMS_TOTAL    = 1050;
  localparam int LATENCY        = 3;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int TIMEOUT_NS     = 2000000;
  localparam int TX_LEVEL       = 1000;
  localparam int TZ_LEVEL       = -500;

  localparam logic [CH_W-1:0]       CH_MAX     = 24'h7FFFFF;
  localparam logic [CH_W-1:0]       CH_MIN     = 24'h800000;
  localparam logic [CFG_IDX_W-1:0]  CFG_UNUSED = 2'd3;
  localparam logic [CFG_DATA_W-1:0] DATA_ALL   = '1;

  typedef logic [NCH-1:0][CH_W-1:0] ft_sample_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    words_pending;
  bit                    calm = 1'b0;
  bit                    squeeze_go = 1'b0;
  int                    words_sent = 0;

  ftbfd_in_if  in_bus ();
  ftbfd_out_if out_bus ();

  force_torque_bias_filter_deadband_core #(
    .CAL_SAMPLES(CAL_N)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  force_torque_bias_filter_deadband_checker #(
    .CAL_SAMPLES(CAL_N)
  ) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .words_pending(words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 7);
  endfunction

  function automatic logic [CH_W-1:0] any_nonzero();
    logic [CH_W-1:0] v;
    do v = CH_W'($urandom()); while (v == '0);
    return v;
  endfunction

  function automatic ft_sample_t fill(input logic [CH_W-1:0] v);
    ft_sample_t s;
    for (int c = 0; c < NCH; c++) s[c] = v;
    return s;
  endfunction

  function automatic ft_sample_t nonzero_sample();
    ft_sample_t s;
    for (int c = 0; c < NCH; c++) s[c] = any_nonzero();
    return s;
  endfunction

  // Mix full-range, near-bias, extreme and dropped channel values
  function automatic ft_sample_t random_sample();
    ft_sample_t s;
    int         base;
    int         v;
    int         mode;
    for (int c = 0; c < NCH; c++) begin
      mode = $urandom_range(99);
      base = (c == 3) ? TX_LEVEL : (c == 5) ? TZ_LEVEL : 0;
      if (mode < 60) begin
        s[c] = any_nonzero();
      end else if (mode < 88) begin
        v = base + int'($urandom_range(16384)) - 8192;
        if (v == 0) v = 1;
        s[c] = CH_W'(v);
      end else if (mode < 98) begin
        case ($urandom_range(3))
          0:       s[c] = CH_MAX;
          1:       s[c] = CH_MIN;
          2:       s[c] = CH_W'(1);
          default: s[c] = '1;
        endcase
      end else begin
        s[c] = '0;
      end
    end
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] band_pick();
    case ($urandom_range(3))
      0:       return '0;
      1:       return DATA_ALL;
      2:       return CFG_DATA_W'($urandom_range(20000));
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  // Offer one word, idling at random, and hold it until accepted
  task automatic send_word(input ft_sample_t s);
    @(negedge clk);
    while (idle_now()) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.force_x  <= s[0];
    in_bus.force_y  <= s[1];
    in_bus.force_z  <= s[2];
    in_bus.torque_x <= s[3];
    in_bus.torque_y <= s[4];
    in_bus.torque_z <= s[5];
    do begin
      @(posedge clk);
    end while (!in_bus.ready);
    words_sent++;
  endtask

  // Drop valid and wait until every owed word has come back
  task automatic drain_words();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] wgt, input logic [CFG_DATA_W-1:0] xy,
                              input logic [CFG_DATA_W-1:0] z, input bit poke);
    drain_words();
    write_reg(CFG_NEW_WEIGHT, wgt);
    write_reg(CFG_XY_DB, xy);
    write_reg(CFG_Z_DB, z);
    if (poke) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls plus one long hold-off to back up the block
  initial begin : receiver
    int hold_left;
    bit squeezed;
    hold_left = 0;
    squeezed = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_go && !squeezed) begin
        squeezed = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !idle_now();
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    ft_sample_t            up;
    ft_sample_t            dn;
    ft_sample_t            s;
    int                    v;
    int                    xy;
    int                    z;
    int                    phase;
    int                    n;
    int                    guard;
    logic [CFG_DATA_W-1:0] wgt;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_bus.valid    = 1'b0;
    in_bus.force_x  = '0;
    in_bus.force_y  = '0;
    in_bus.force_z  = '0;
    in_bus.torque_x = '0;
    in_bus.torque_y = '0;
    in_bus.torque_z = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Calibration that fails: every channel sums to zero over cancelling pairs
    for (int k = 0; k < CAL_N / 2; k++) begin
      for (int c = 0; c < NCH; c++) begin
        v = int'($urandom_range(16777214)) - 8388607;
        up[c] = CH_W'(v);
        dn[c] = CH_W'(-v);
      end
      send_word(up);
      send_word(dn);
    end

    // Calibration that succeeds: extreme, fixed and random channel levels
    for (int k = 0; k < CAL_N; k++) begin
      s[0] = CH_MIN;
      s[1] = CH_MAX;
      s[2] = CH_W'($urandom());
      s[3] = CH_W'(TX_LEVEL);
      s[4] = CH_W'(int'($urandom_range(8000000)) - 5000000);
      s[5] = CH_W'(TZ_LEVEL);
      send_word(s);
    end

    // Extremes with the default registers
    send_word(fill(CH_MAX));
    send_word(fill(CH_MIN));
    send_word(fill(CH_W'(1)));
    send_word(fill('1));

    // Drop a sample for a zero on each channel in turn
    for (int c = 0; c < NCH; c++) begin
      s = nonzero_sample();
      s[c] = '0;
      send_word(s);
    end

    // Unity weight passes the debiased value, so hit the deadband edges exactly
    program_regs(CFG_DATA_W'(ONE_Q16), CFG_DATA_W'(XY_DB_RST), CFG_DATA_W'(Z_DB_RST), 1'b0);
    xy = int'(XY_DB_RST);
    z = int'(Z_DB_RST);
    s = fill(CH_W'(1));
    s[3] = CH_W'(TX_LEVEL + xy);
    s[5] = CH_W'(TZ_LEVEL + z);
    send_word(s);
    s[3] = CH_W'(TX_LEVEL + xy - 1);
    s[5] = CH_W'(TZ_LEVEL + z - 1);
    send_word(s);
    s[3] = CH_W'(TX_LEVEL - xy);
    s[5] = CH_W'(TZ_LEVEL - z);
    send_word(s);
    s[3] = CH_W'(TX_LEVEL - xy + 1);
    s[5] = CH_W'(TZ_LEVEL - z + 1);
    send_word(s);

    // Zero weight, deadbands at both ends
    program_regs('0, '0, DATA_ALL, 1'b0);
    send_word(nonzero_sample());
    send_word(nonzero_sample());

    // Weight field all ones saturates; poke the unused index
    program_regs(DATA_ALL, CFG_DATA_W'(XY_DB_RST), CFG_DATA_W'(Z_DB_RST), 1'b1);
    send_word(nonzero_sample());
    send_word(nonzero_sample());

    // Weight just above unity
    program_regs(CFG_DATA_W'(int'(ONE_Q16) + 1), DATA_ALL, '0, 1'b0);
    send_word(nonzero_sample());
    send_word(nonzero_sample());

    // Random phases, each with its own register setting
    phase = 0;
    while (words_sent < ITEMS_TOTAL) begin
      phase++;
      case ($urandom_range(4))
        0:       wgt = '0;
        1:       wgt = CFG_DATA_W'(ONE_Q16);
        2:       wgt = CFG_DATA_W'($urandom_range(65536));
        3:       wgt = CFG_DATA_W'($urandom_range(131071, 65537));
        default: wgt = CFG_DATA_W'($urandom());
      endcase
      program_regs(wgt, band_pick(), band_pick(), $urandom_range(3) == 0);
      calm = (phase == 3);
      if (phase == 5) squeeze_go = 1'b1;
      n = calm ? 150 : $urandom_range(120, 40);
      repeat (n) send_word(random_sample());
    end
    calm = 1'b0;

    // Drain with a bound, then give the verdict
    @(negedge clk);
    in_bus.valid <= 1'b0;
    guard = 0;
    while (words_pending != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 2) @(negedge clk);
    if (mismatches == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
